// ===== sv/stable_priority_queue_assert.svh =====
// Assertion macros for the sorted priority queue.
// SPQ_ASSERT checks a property while out of reset; SPQ_ASSERT_ALWAYS checks it on every edge.
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTH
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/spq_pkg.sv =====
package spq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OCC_W  = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // Command broadcast to every cell in the row.
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [DATA_W-1:0] data;
    logic signed [DATA_W-1:0] prio;
  } spq_ctrl_t;

endpackage

// ===== sv/spq_cell.sv =====
module spq_cell (
  input  logic                             clk_i,
  input  spq_pkg::spq_ctrl_t               ctrl_i,
  input  logic                             occ_i,
  input  logic                             left_gt_i,
  input  logic signed [spq_pkg::DATA_W-1:0] left_data_i,
  input  logic signed [spq_pkg::DATA_W-1:0] left_prio_i,
  input  logic signed [spq_pkg::DATA_W-1:0] right_data_i,
  input  logic signed [spq_pkg::DATA_W-1:0] right_prio_i,
  output logic                             gt_o,
  output logic signed [spq_pkg::DATA_W-1:0] data_o,
  output logic signed [spq_pkg::DATA_W-1:0] prio_o
);
  import spq_pkg::*;

  logic signed [DATA_W-1:0] data_q, data_d;
  logic signed [DATA_W-1:0] prio_q, prio_d;

  // Held entry sorts behind the new word: it must move back one slot.
  assign gt_o   = occ_i && (prio_q > ctrl_i.prio);
  assign data_o = data_q;
  assign prio_o = prio_q;

  always_comb begin
    data_d = data_q;
    prio_d = prio_q;
    if (ctrl_i.ins) begin
      if (left_gt_i) begin
        data_d = left_data_i;
        prio_d = left_prio_i;
      end else if (gt_o || !occ_i) begin
        data_d = ctrl_i.data;
        prio_d = ctrl_i.prio;
      end
    end else if (ctrl_i.rem) begin
      // advance toward the front
      data_d = right_data_i;
      prio_d = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

endmodule

// ===== sv/stable_priority_queue.sv =====
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_stall_o   | opcode_i, item_data_i, item_priority_i
// out     | output    | out_valid_o / out_stall_i | removed_data_o, status_o, occupancy_o
//
// Every word is handled at once: the row of cells compares all held
// priorities against the new one in parallel and all cells shift together.
// The result shows on the cycle after acceptance; one word per cycle is taken
// while the output is free or being drained.
// Reset empties the queue (fill count zero); cell contents need no reset.
// A stalled output holds its word and stalls the input.
module stable_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              opcode_i,
  input  logic signed [spq_pkg::DATA_W-1:0] item_data_i,
  input  logic signed [spq_pkg::DATA_W-1:0] item_priority_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [spq_pkg::DATA_W-1:0] removed_data_o,
  output logic [1:0]                        status_o,
  output logic [spq_pkg::OCC_W-1:0]         occupancy_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     accept;
  logic                     is_full, is_empty;
  logic                     is_rem;
  spq_ctrl_t                ctrl;
  logic [QUEUE_DEPTH-1:0]   cell_gt;
  logic signed [DATA_W-1:0] cell_data [QUEUE_DEPTH];
  logic signed [DATA_W-1:0] cell_prio [QUEUE_DEPTH];
  logic [CntW+OCC_W-1:0]    cnt_ext;

  logic                     out_valid_q;
  logic signed [DATA_W-1:0] rdata_q;
  status_e                  status_q, status_d;
  logic [OCC_W-1:0]         occ_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_full    = (cnt_q == CntW'(QUEUE_DEPTH));
  assign is_empty   = (cnt_q == '0);
  assign is_rem     = (opcode_i == OP_REMOVE);

  always_comb begin
    ctrl.ins  = accept && !is_rem && !is_full;
    ctrl.rem  = accept && is_rem && !is_empty;
    ctrl.data = item_data_i;
    ctrl.prio = item_priority_i;
    cnt_d     = cnt_q;
    if (ctrl.ins) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (ctrl.rem) begin
      cnt_d = cnt_q - CntW'(1);
    end
    if (!is_rem) begin
      status_d = is_full ? ST_FULL : ST_INSERTED;
    end else begin
      status_d = is_empty ? ST_EMPTY : ST_REMOVED;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam logic [CntW-1:0] Idx = CntW'(i);
    logic                     left_gt;
    logic signed [DATA_W-1:0] left_data, left_prio, right_data, right_prio;

    if (i == 0) begin : g_head
      assign left_gt   = 1'b0;
      assign left_data = '0;
      assign left_prio = '0;
    end else begin : g_mid
      assign left_gt   = cell_gt[i-1];
      assign left_data = cell_data[i-1];
      assign left_prio = cell_prio[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_data = cell_data[i];
      assign right_prio = cell_prio[i];
    end else begin : g_body
      assign right_data = cell_data[i+1];
      assign right_prio = cell_prio[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (Idx < cnt_q),
      .left_gt_i    (left_gt),
      .left_data_i  (left_data),
      .left_prio_i  (left_prio),
      .right_data_i (right_data),
      .right_prio_i (right_prio),
      .gt_o         (cell_gt[i]),
      .data_o       (cell_data[i]),
      .prio_o       (cell_prio[i])
    );
  end

  assign cnt_ext = {{OCC_W{1'b0}}, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q  <= ctrl.rem ? cell_data[0] : '0;
      status_q <= status_d;
      occ_q    <= cnt_ext[OCC_W-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign removed_data_o = rdata_q;
  assign status_o       = status_q;
  assign occupancy_o    = occ_q;

`include "stable_priority_queue_assert.svh"

  `SPQ_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(QUEUE_DEPTH), "fill count above depth")
  `SPQ_ASSERT(a_ins_grow, clk_i, rst_ni, ctrl.ins |=> (cnt_q == $past(cnt_q) + CntW'(1)) && (status_q == ST_INSERTED), "insert did not grow queue")
  `SPQ_ASSERT(a_rem_front, clk_i, rst_ni, ctrl.rem |=> (rdata_q == $past(cell_data[0])) && (status_q == ST_REMOVED), "remove lost the front word")
  `SPQ_ASSERT(a_head_order, clk_i, rst_ni, (cnt_q >= CntW'(2)) |-> (cell_prio[0] <= cell_prio[1]), "front cells out of order")
  `SPQ_ASSERT_ALWAYS(a_stall_gate, clk_i, in_stall_o |-> out_valid_q, "input stalled with empty output")

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  import spq_pkg::*;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned RANDOM_WORDS = 2000;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned DIRECTED_ROWS = 25;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_data;
    status_e                  status;
    logic [OCC_W-1:0]         occupancy;
  } outcome_t;

  typedef struct packed {
    op_e                      op;
    logic signed [DATA_W-1:0] data;
    logic signed [DATA_W-1:0] prio;
    logic                     typed;
    outcome_t                 outcome;
  } stim_row_t;

  // Rows with typed == 1 carry their result; the rest are predicted.
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0, ST_EMPTY, 5'd0}},
    '{OP_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, '{32'h0, ST_INSERTED, 5'd1}},
    '{OP_INSERT, 32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h0, ST_INSERTED, 5'd2}},
    '{OP_INSERT, 32'h0000_0001, 32'h0000_0000, 1'b1, '{32'h0, ST_INSERTED, 5'd3}},
    '{OP_INSERT, 32'h0000_0002, 32'h0000_0000, 1'b1, '{32'h0, ST_INSERTED, 5'd4}},
    '{OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h8000_0000, ST_REMOVED, 5'd3}},
    '{OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h1, ST_REMOVED, 5'd2}},
    '{OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h2, ST_REMOVED, 5'd1}},
    '{OP_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, '{32'h0, ST_INSERTED, 5'd0}},
    '{OP_INSERT, 32'h0000_0000, 32'h8000_0000, 1'b0, '{32'h0, ST_INSERTED, 5'd0}},
    '{OP_INSERT, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 1'b0, '{32'h0, ST_INSERTED, 5'd0}},
    '{OP_INSERT, 32'h5555_5555, 32'h0000_0000, 1'b0, '{32'h0, ST_INSERTED, 5'd0}},
    '{OP_INSERT, 32'h0000_0011, 32'h0000_0001, 1'b0, '{32'h0, ST_INSERTED, 5'd0}},
    '{OP_INSERT, 32'h0000_0012, 32'h0000_0000, 1'b0, '{32'h0, ST_INSERTED, 5'd0}},
    '{OP_INSERT, 32'h0000_0013, 32'hFFFF_FFFF, 1'b0, '{32'h0, ST_INSERTED, 5'd0}},
    '{OP_INSERT, 32'h8000_0000, 32'h8000_0000, 1'b0, '{32'h0, ST_INSERTED, 5'd0}},
    '{OP_INSERT, 32'h7FFF_FFFF, 32'h0000_0005, 1'b0, '{32'h0, ST_INSERTED, 5'd0}},
    '{OP_INSERT, 32'h0000_0015, 32'h0000_0005, 1'b0, '{32'h0, ST_INSERTED, 5'd0}},
    '{OP_INSERT, 32'h0000_0016, 32'h7FFF_FFFE, 1'b0, '{32'h0, ST_INSERTED, 5'd0}},
    '{OP_INSERT, 32'h0000_0017, 32'hFFFF_FF9C, 1'b0, '{32'h0, ST_INSERTED, 5'd0}},
    '{OP_INSERT, 32'h0000_0018, 32'h0000_0064, 1'b0, '{32'h0, ST_INSERTED, 5'd0}},
    '{OP_INSERT, 32'h0000_0019, 32'h0000_0003, 1'b0, '{32'h0, ST_INSERTED, 5'd0}},
    '{OP_INSERT, 32'h0000_001A, 32'h0000_0003, 1'b0, '{32'h0, ST_INSERTED, 5'd0}},
    '{OP_INSERT, 32'h1234_5678, 32'h8000_0000, 1'b1, '{32'h0, ST_FULL, 5'd16}},
    '{OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0, '{32'h0, ST_INSERTED, 5'd0}}
  };

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     opcode_i;
  logic signed [DATA_W-1:0] item_data_i;
  logic signed [DATA_W-1:0] item_priority_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [DATA_W-1:0] removed_data_o;
  logic [1:0]               status_o;
  logic [OCC_W-1:0]         occupancy_o;

  // Typed result that travels with the word on the input side.
  logic                     word_typed;
  outcome_t                 word_outcome;

  logic signed [DATA_W-1:0] held_data [SLOTS];
  logic signed [DATA_W-1:0] held_prio [SLOTS];
  int unsigned              held_count;
  outcome_t                 owed_results [$];
  bit                       failed;
  bit                       calm;
  int unsigned              idle_cycles;

  stable_priority_queue i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .item_data_i     (item_data_i),
    .item_priority_i (item_priority_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .removed_data_o  (removed_data_o),
    .status_o        (status_o),
    .occupancy_o     (occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Mostly no gap, some short, a few long; none at all during calm stretches.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Sorted insert behind equal priorities, remove from the front.
  function automatic outcome_t rank_and_serve(op_e op, logic signed [DATA_W-1:0] data,
                                              logic signed [DATA_W-1:0] prio);
    outcome_t    res;
    int unsigned slot;
    int unsigned idx;
    res.removed_data = '0;
    res.status = ST_INSERTED;
    if (op == OP_INSERT) begin
      if (held_count >= SLOTS) begin
        res.status = ST_FULL;
      end else begin
        slot = 0;
        while (slot < held_count && held_prio[slot] <= prio) slot++;
        for (idx = held_count; idx > slot; idx--) begin
          held_data[idx] = held_data[idx-1];
          held_prio[idx] = held_prio[idx-1];
        end
        held_data[slot] = data;
        held_prio[slot] = prio;
        held_count++;
      end
    end else if (held_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.removed_data = held_data[0];
      res.status = ST_REMOVED;
      for (idx = 1; idx < held_count; idx++) begin
        held_data[idx-1] = held_data[idx];
        held_prio[idx-1] = held_prio[idx];
      end
      held_count--;
    end
    res.occupancy = held_count[OCC_W-1:0];
    return res;
  endfunction

  // Called at a rising edge; returns at the edge where the word is taken.
  task automatic send_word(input stim_row_t row);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= row.op;
    item_data_i     <= row.data;
    item_priority_i <= row.prio;
    word_typed      <= row.typed;
    word_outcome    <= row.outcome;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_priority();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return $signed(32'($urandom_range(0, 7))) - 4;
    if (roll < 80) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  always @(posedge clk_i) begin
    outcome_t want;
    outcome_t got;
    bit       moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (owed_results.size() == 0) begin
          $error("result word with none owed: data %0d status %0d occupancy %0d",
                 removed_data_o, status_o, occupancy_o);
          failed = 1'b1;
        end else begin
          want = owed_results.pop_front();
          if (removed_data_o !== want.removed_data) begin
            $error("removed_data: expected %0d, got %0d", want.removed_data, removed_data_o);
            failed = 1'b1;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            failed = 1'b1;
          end
          if (occupancy_o !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy_o);
            failed = 1'b1;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        got = rank_and_serve(op_e'(opcode_i), item_data_i, item_priority_i);
        owed_results.push_back(word_typed ? word_outcome : got);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Output stall: random stretches of stall and release.
  initial begin
    int unsigned hold;
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  initial begin
    stim_row_t   row;
    int unsigned sent;
    int unsigned burst_len;
    int unsigned bias;
    int unsigned n;
    failed          = 1'b0;
    calm            = 1'b0;
    idle_cycles     = 0;
    held_count      = 0;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    opcode_i        <= OP_INSERT;
    item_data_i     <= '0;
    item_priority_i <= '0;
    word_typed      <= 1'b0;
    word_outcome    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < DIRECTED_ROWS; n++) send_word(DIRECTED[n]);

    // Bursts that lean to filling, to draining, or neither; some without idling.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst_len = $urandom_range(10, 60);
      case ($urandom_range(0, 3))
        0: begin bias = 85; calm = 1'b0; end
        1: begin bias = 15; calm = 1'b0; end
        2: begin bias = 50; calm = 1'b0; end
        default: begin bias = 55; calm = 1'b1; end
      endcase
      for (n = 0; n < burst_len; n++) begin
        row.op      = ($urandom_range(0, 99) < bias) ? OP_INSERT : OP_REMOVE;
        row.data    = $urandom;
        row.prio    = pick_priority();
        row.typed   = 1'b0;
        row.outcome = '0;
        send_word(row);
        sent++;
      end
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    if (!failed && owed_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
